// ----- rtl/ilcm_pkg.sv -----
// ilcm_pkg: shared types and constants for the multi-width LCM block.
// No dependencies.
`timescale 1ns / 1ps
package ilcm_pkg;
	localparam int unsigned DataW = 64;
	localparam int unsigned CntW  = 7;
	typedef logic [DataW-1:0] word_t;
	typedef logic [1:0] wmode_t;
	localparam wmode_t WM_8  = 2'd0;
	localparam wmode_t WM_16 = 2'd1;
	localparam wmode_t WM_32 = 2'd2;
	localparam wmode_t WM_64 = 2'd3;

	// sign-extend low element bits
	function automatic word_t sext_w(input word_t v, input wmode_t m);
		word_t r;
		r = v;
		unique case (m)
			WM_8:  r = {{56{v[7]}}, v[7:0]};
			WM_16: r = {{48{v[15]}}, v[15:0]};
			WM_32: r = {{32{v[31]}}, v[31:0]};
			WM_64: r = v;
			default: r = v;
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/ilcm_div.sv -----
// ilcm_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on ilcm_pkg.
`timescale 1ns / 1ps
module ilcm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  ilcm_pkg::word_t   num,
	input  ilcm_pkg::word_t   den,
	output logic              done,
	output ilcm_pkg::word_t   quo,
	output ilcm_pkg::word_t   rem
);
	logic [ilcm_pkg::CntW-1:0] cnt_q;
	logic busy_q;
	logic [ilcm_pkg::DataW:0] trial;
	ilcm_pkg::word_t d_q;
	assign trial = {rem, quo[ilcm_pkg::DataW-1]} - {1'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ilcm_pkg::CntW'(ilcm_pkg::DataW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			quo <= num;
			rem <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[ilcm_pkg::DataW]) begin
				rem <= trial[ilcm_pkg::DataW-1:0];
				quo <= {quo[ilcm_pkg::DataW-2:0], 1'b1};
			end else begin
				rem <= {rem[ilcm_pkg::DataW-2:0], quo[ilcm_pkg::DataW-1]};
				quo <= {quo[ilcm_pkg::DataW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- rtl/ilcm_mul.sv -----
// ilcm_mul: bit-serial shift-add multiplier, product modulo 2^64.
// Depends on ilcm_pkg.
`timescale 1ns / 1ps
module ilcm_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  ilcm_pkg::word_t   x,
	input  ilcm_pkg::word_t   y,
	output logic              done,
	output ilcm_pkg::word_t   prod
);
	ilcm_pkg::word_t x_q, y_q;
	logic [ilcm_pkg::CntW-1:0] cnt_q;
	logic busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ilcm_pkg::CntW'(ilcm_pkg::DataW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			x_q  <= x;
			y_q  <= y;
			prod <= '0;
		end else if (busy_q) begin
			if (y_q[0]) prod <= prod + x_q;
			x_q <= {x_q[ilcm_pkg::DataW-2:0], 1'b0};
			y_q <= {1'b0, y_q[ilcm_pkg::DataW-1:1]};
		end
	end
endmodule

// ----- rtl/integer_lcm_multiwidth.sv -----
// integer_lcm_multiwidth: top level, Euclid gcd via serial divider, then serial multiply.
// Depends on ilcm_pkg, ilcm_div, ilcm_mul.
//
//  channel   handshake               word
//  input     start & !busy           operand_a, operand_b
//  config    cfg_valid & cfg_ready   cfg_data (width_mode)
//  result    done strobe, 1 cycle    lcm_value
//
// Each Euclid modulo step and the final divide run in the shared divider, then the multiply
// runs in the serial multiplier. A zero operand goes to ST_ZERO and returns 0. Reset gives
// width_mode 32-bit. cfg_ready is high while idle. The receiver cannot stall the result.
`timescale 1ns / 1ps
module integer_lcm_multiwidth (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       operand_a,
	input  logic [63:0]       operand_b,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data,
	output logic              done,
	output logic [63:0]       lcm_value
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_QUO  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;
	logic [2:0] st_q;
	ilcm_pkg::wmode_t wm_q;
	ilcm_pkg::word_t ua_q, ub_q, x_q, y_q;
	ilcm_pkg::word_t sa, sb, ma, mb, quo, rem, prod, r;
	logic div_go, div_done, mul_go, mul_done;

	assign sa = ilcm_pkg::sext_w(operand_a, wm_q);
	assign sb = ilcm_pkg::sext_w(operand_b, wm_q);
	assign ma = sa[63] ? (64'd0 - sa) : sa;
	assign mb = sb[63] ? (64'd0 - sb) : sb;
	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = !busy;

	ilcm_div u_div (.clk, .arst_n, .go(div_go), .num(x_q), .den(y_q),
		.done(div_done), .quo, .rem);
	ilcm_mul u_mul (.clk, .arst_n, .go(mul_go), .x(x_q), .y(ub_q),
		.done(mul_done), .prod);

	always_comb begin
		r = ilcm_pkg::sext_w(prod, wm_q);
		if (wm_q == ilcm_pkg::WM_64 && prod[63]) r = 64'd0 - prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			wm_q   <= ilcm_pkg::WM_32;
			done   <= 1'b0;
			div_go <= 1'b0;
			mul_go <= 1'b0;
		end else begin
			done   <= 1'b0;
			div_go <= 1'b0;
			mul_go <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (cfg_valid) wm_q <= cfg_data;
					if (start) begin
						if (sa == '0 || sb == '0) begin
							st_q <= ST_ZERO;
						end else begin
							st_q   <= ST_GCD;
							div_go <= 1'b1;
						end
					end
				end
				ST_GCD: if (div_done) begin
					if (rem == '0) begin
						st_q   <= ST_QUO;
						div_go <= 1'b1;
					end else begin
						div_go <= 1'b1;
					end
				end
				ST_QUO: if (div_done) begin
					st_q   <= ST_MUL;
					mul_go <= 1'b1;
				end
				ST_MUL: if (mul_done) begin
					st_q <= ST_IDLE;
					done <= 1'b1;
				end
				ST_ZERO: begin
					st_q <= ST_IDLE;
					done <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			ua_q <= ma;
			ub_q <= mb;
			x_q  <= ma;
			y_q  <= mb;
		end else if (st_q == ST_GCD && div_done) begin
			if (rem == '0) begin
				x_q <= ua_q;
			end else begin
				x_q <= y_q;
				y_q <= rem;
			end
		end else if (st_q == ST_QUO && div_done) begin
			x_q <= quo;
		end
		if (st_q == ST_ZERO) lcm_value <= '0;
		else if (st_q == ST_MUL && mul_done) lcm_value <= r;
	end

	// gcd divisor is never zero once started
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_go && st_q != ST_IDLE |-> y_q != '0) else $error("zero divisor");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_IDLE) else $error("done while busy");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ZERO |=> done && lcm_value == '0) else $error("zero path");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(wm_q)) else $error("mode changed while busy");
endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking regression for integer_lcm_multiwidth (signed LCM at 8/16/32/64 bits).
// Depends on ilcm_pkg and rtl/integer_lcm_multiwidth.sv; predicts each word and compares.
`timescale 1ns / 1ps
module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = '0;
	logic done;
	logic [63:0] lcm_value;

	integer_lcm_multiwidth u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operand_a(operand_a), .operand_b(operand_b),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .lcm_value(lcm_value)
	);

	always #10 clk = ~clk;

	ilcm_pkg::wmode_t cur_mode = ilcm_pkg::WM_32;
	ilcm_pkg::word_t lcm_expect_q[$];
	int unsigned errors = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned idle_pct = 27;
	int unsigned mode_uses[4];

	function automatic ilcm_pkg::word_t elem_sext(input ilcm_pkg::word_t v,
		input ilcm_pkg::wmode_t m);
		ilcm_pkg::word_t r;
		case (m)
			ilcm_pkg::WM_8:  r = {{56{v[7]}}, v[7:0]};
			ilcm_pkg::WM_16: r = {{48{v[15]}}, v[15:0]};
			ilcm_pkg::WM_32: r = {{32{v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic ilcm_pkg::word_t lcm_predict(input ilcm_pkg::word_t a_in,
		input ilcm_pkg::word_t b_in, input ilcm_pkg::wmode_t m);
		ilcm_pkg::word_t a, b, ua, ub, x, y, t, g;
		logic [127:0] prod;
		ilcm_pkg::word_t r;
		a = elem_sext(a_in, m);
		b = elem_sext(b_in, m);
		if (a == 0 || b == 0)
			return '0;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		x = ua;
		y = ub;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		g = (x == 0) ? 64'd1 : x;
		prod = (ua / g) * ub;
		r = prod[63:0];
		if (m != ilcm_pkg::WM_64)
			r = elem_sext(r, m);
		else if (r[63])
			r = -r;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lcm_expect_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word lcm_value=%h", $time, lcm_value);
			end else begin
				ilcm_pkg::word_t e;
				e = lcm_expect_q.pop_front();
				words_checked++;
				if (e !== lcm_value) begin
					errors++;
					$display("%0t: lcm_value mismatch expected %h actual %h",
						$time, e, lcm_value);
				end
			end
		end
	end

	// busy covers at least the cycle after an accept, so the extra negedge costs no rate
	task automatic send_word(input ilcm_pkg::word_t a, input ilcm_pkg::word_t b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		lcm_expect_q.push_back(lcm_predict(a, b, cur_mode));
		words_sent++;
		mode_uses[cur_mode]++;
		@(negedge clk);
		start <= 1'b0;
		operand_a <= {$urandom, $urandom};
		operand_b <= {$urandom, $urandom};
	endtask

	task automatic drain();
		while (lcm_expect_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_mode(input ilcm_pkg::wmode_t m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic ilcm_pkg::word_t rand_operand(input ilcm_pkg::wmode_t m);
		ilcm_pkg::word_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0: v = '0;
			1: v = elem_sext(64'h1, m) << ($urandom_range(7));
			2: v = -(ilcm_pkg::word_t'($urandom_range(40)));
			3: v = ilcm_pkg::word_t'($urandom_range(300));
			4: v = ilcm_pkg::word_t'($urandom_range(6)) *
				ilcm_pkg::word_t'($urandom_range(5000));
			default: ;
		endcase
		// small magnitudes keep 64-bit Euclid short on most words
		if (m == ilcm_pkg::WM_64 && $urandom_range(3) != 0)
			v = {{40{v[23]}}, v[23:0]};
		return v;
	endfunction

	task automatic test_reset_mode();
		send_word(64'd12, 64'd18);
		send_word(64'hFFFF_FFFF_8000_0000, 64'd3);
	endtask

	task automatic test_directed(input ilcm_pkg::wmode_t m);
		ilcm_pkg::word_t mn, mx;
		write_mode(m);
		mn = elem_sext(64'h1 << (8 * (1 << m) - 1), m);
		mx = ~mn;
		send_word(64'd0, 64'd7);
		send_word(-64'sd5, 64'd0);
		send_word(mn, 64'd1);
		send_word(mn, mn);
		send_word(mx, mx - 1);
		send_word(-64'sd1, -64'sd1);
		send_word(64'hA5A5_A5A5_A5A5_A506, 64'h5A5A_5A5A_5A5A_5A04);
		send_word(mx, mn);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
	endtask

	task automatic test_random(input int unsigned n);
		ilcm_pkg::wmode_t m;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 60 == 0) begin
				m = ilcm_pkg::wmode_t'($urandom_range(3));
				write_mode(m);
			end
			send_word(rand_operand(cur_mode), rand_operand(cur_mode));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_mode();
		test_directed(ilcm_pkg::WM_8);
		test_directed(ilcm_pkg::WM_64);
		test_directed(ilcm_pkg::WM_16);
		test_directed(ilcm_pkg::WM_32);
		idle_pct = 27;
		test_random(640);
		idle_pct = 80;
		test_random(600);
		idle_pct = 0;
		test_random(640);
		write_mode(ilcm_pkg::WM_64);
		drain();
		repeat (20) @(posedge clk);
		$display("%0d words sent, %0d checked; per width 8/16/32/64: %0d %0d %0d %0d",
			words_sent, words_checked, mode_uses[0], mode_uses[1], mode_uses[2],
			mode_uses[3]);
		if (errors == 0 && lcm_expect_q.size() == 0)
			$display("integer_lcm_multiwidth regression: pass");
		else
			$display("integer_lcm_multiwidth regression: fail");
		$finish;
	end

	initial begin
		#1_500_000_000;
		$display("integer_lcm_multiwidth regression: fail");
		$finish;
	end
endmodule

// ----- integer_lcm_multiwidth.f -----
rtl/ilcm_pkg.sv
rtl/ilcm_div.sv
rtl/ilcm_mul.sv
rtl/integer_lcm_multiwidth.sv
tb/tb_top.sv
